>>> hdl/shamh_pkg.sv
// shared types, constants and functions for the sha-256 message hasher
`timescale 1ns / 1ps
`default_nettype none
package shamh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    // working variables of the compression rounds
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } work_t;

    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned WIN_WORDS   = 16;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LAST_ROUND  = 6'd63;
    localparam logic [5:0]  LAST_FILL   = 6'd63;
    localparam logic [5:0]  LEN_START   = 6'd56;
    localparam logic [2:0]  LAST_WORD   = 3'd7;

    function automatic logic [31:0] initial_h(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] v;
        case (t)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;
            default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage
`default_nettype wire

>>> hdl/sha256_message_hasher.sv
// top level of the streaming sha-256 message hasher
`timescale 1ns / 1ps
`default_nettype none
// Takes a message one byte per request and returns its SHA-256 digest as eight
// 32-bit words, H0 first. Byte requests are accepted while idle; the request that
// fills a 64-byte block is followed by compression (64 rounds through one shared
// round unit, then a fold of the result into the hash). The request that ends the
// message is followed by the padding and length bytes (9 to 72), one or two
// compressions, then the eight digest words, one per accepted output request.
// The input is not ready during compression, padding or digest output. After the
// last digest word the hash state and byte count return to their initial values
// for the next message.
module sha256_message_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // message_end
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [31:0] m_tdata,   // [31:0] digest_word
    output      logic [2:0]  m_tuser,   // [2:0] word_index
    output      logic        m_tlast    // last_word
);

    localparam int unsigned NH = shamh_pkg::HASH_WORDS;
    localparam int unsigned NW = shamh_pkg::WIN_WORDS;

    shamh_pkg::state_t state_reg, state_next;

    logic [5:0]  round_reg;
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic        pad_reg, pad_next;
    logic        sent80_reg, sent80_next;
    logic        len_reg, len_next;
    logic [2:0]  out_idx_reg;
    logic [31:0] hash_reg [NH];
    logic [31:0] win_reg [NW];
    shamh_pkg::work_t work_reg;
    shamh_pkg::work_t work_round;

    logic        shift_en;
    logic [7:0]  shift_byte;
    logic        count_inc;
    logic        load_work;
    logic        fold_en;
    logic        out_pop;
    logic        msg_done;
    logic [63:0] bit_len;
    logic [5:0]  len_lsb;
    logic [7:0]  len_byte;
    logic [31:0] sched_new;

    assign bit_len  = {count_reg, 3'b000};
    assign len_lsb  = {~fill_reg[2:0], 3'b000};
    assign len_byte = bit_len[len_lsb +: 8];

    // window holds W[t..t+15] during rounds, so the new word is W[t+16]
    assign sched_new = shamh_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                     + shamh_pkg::small_sigma0(win_reg[1]) + win_reg[0];

    shamh_round u_round (
        .work_in    (work_reg),
        .round_key  (shamh_pkg::round_k(round_reg)),
        .sched_word (win_reg[0]),
        .work_out   (work_round)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= shamh_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        shift_en    = 1'b0;
        shift_byte  = s_tdata;
        count_inc   = 1'b0;
        load_work   = 1'b0;
        fold_en     = 1'b0;
        out_pop     = 1'b0;
        msg_done    = 1'b0;
        pad_next    = pad_reg;
        sent80_next = sent80_reg;
        len_next    = len_reg;
        unique case (state_reg)
            shamh_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    pad_next = s_tlast;
                    if (s_tuser[0]) begin
                        shift_en  = 1'b1;
                        count_inc = 1'b1;
                    end
                    if (s_tuser[0] && fill_reg == shamh_pkg::LAST_FILL) begin
                        load_work  = 1'b1;
                        state_next = shamh_pkg::ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = shamh_pkg::ST_PAD;
                    end
                end
            end
            shamh_pkg::ST_PAD: begin
                shift_en    = 1'b1;
                sent80_next = 1'b1;
                if (!sent80_reg) begin
                    shift_byte = shamh_pkg::PAD_BYTE;
                end else if (len_reg || fill_reg == shamh_pkg::LEN_START) begin
                    shift_byte = len_byte;
                    len_next   = 1'b1;
                end else begin
                    shift_byte = 8'h00;
                end
                if (fill_reg == shamh_pkg::LAST_FILL) begin
                    load_work  = 1'b1;
                    state_next = shamh_pkg::ST_ROUND;
                end
            end
            shamh_pkg::ST_ROUND: begin
                if (round_reg == shamh_pkg::LAST_ROUND) begin
                    state_next = shamh_pkg::ST_FOLD;
                end
            end
            shamh_pkg::ST_FOLD: begin
                fold_en = 1'b1;
                if (!pad_reg) begin
                    state_next = shamh_pkg::ST_IDLE;
                end else if (len_reg) begin
                    state_next = shamh_pkg::ST_OUT;
                end else begin
                    state_next = shamh_pkg::ST_PAD;
                end
            end
            shamh_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    out_pop = 1'b1;
                    if (out_idx_reg == shamh_pkg::LAST_WORD) begin
                        msg_done   = 1'b1;
                        state_next = shamh_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = shamh_pkg::ST_IDLE;
            end
        endcase
        if (msg_done) begin
            pad_next    = 1'b0;
            sent80_next = 1'b0;
            len_next    = 1'b0;
        end
    end

    // control and hash state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg   <= '0;
            fill_reg    <= '0;
            count_reg   <= '0;
            pad_reg     <= 1'b0;
            sent80_reg  <= 1'b0;
            len_reg     <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < NH; i++) begin
                hash_reg[i] <= shamh_pkg::initial_h(3'(i));
            end
        end else begin
            pad_reg    <= pad_next;
            sent80_reg <= sent80_next;
            len_reg    <= len_next;
            if (shift_en) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (load_work) begin
                round_reg <= '0;
            end else if (state_reg == shamh_pkg::ST_ROUND) begin
                round_reg <= round_reg + 6'd1;
            end
            if (msg_done) begin
                count_reg <= '0;
            end else if (count_inc) begin
                count_reg <= count_reg + 61'd1;
            end
            if (fold_en) begin
                hash_reg[0] <= hash_reg[0] + work_reg.a;
                hash_reg[1] <= hash_reg[1] + work_reg.b;
                hash_reg[2] <= hash_reg[2] + work_reg.c;
                hash_reg[3] <= hash_reg[3] + work_reg.d;
                hash_reg[4] <= hash_reg[4] + work_reg.e;
                hash_reg[5] <= hash_reg[5] + work_reg.f;
                hash_reg[6] <= hash_reg[6] + work_reg.g;
                hash_reg[7] <= hash_reg[7] + work_reg.h;
            end else if (msg_done) begin
                for (int i = 0; i < NH; i++) begin
                    hash_reg[i] <= shamh_pkg::initial_h(3'(i));
                end
            end else if (out_pop) begin
                // digest leaves from word 0, the rest move down
                for (int i = 0; i < NH - 1; i++) begin
                    hash_reg[i] <= hash_reg[i + 1];
                end
            end
            if (msg_done) begin
                out_idx_reg <= '0;
            end else if (out_pop) begin
                out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

    // block window and working variables
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            // bytes enter big-endian, first byte ends up in the top of word 0
            for (int i = 0; i < NW - 1; i++) begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_reg[NW - 1] <= {win_reg[NW - 1][23:0], shift_byte};
        end else if (state_reg == shamh_pkg::ST_ROUND) begin
            for (int i = 0; i < NW - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[NW - 1] <= sched_new;
        end
        if (load_work) begin
            work_reg <= {hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                         hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};
        end else if (state_reg == shamh_pkg::ST_ROUND) begin
            work_reg <= work_round;
        end
    end

    assign m_tdata = hash_reg[0];
    assign m_tuser = out_idx_reg;
    assign m_tlast = (out_idx_reg == shamh_pkg::LAST_WORD);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest is being sent");

    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == shamh_pkg::ST_ROUND) |-> (fill_reg == '0))
        else $error("compression running on a partial block");

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == shamh_pkg::ST_ROUND && round_reg == shamh_pkg::LAST_ROUND)
        |=> (state_reg == shamh_pkg::ST_FOLD))
        else $error("last round not followed by hash fold");

    a_msg_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast)
        |=> (count_reg == '0 && fill_reg == '0 && s_tready))
        else $error("state not cleared after digest");

    a_digest_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (len_reg && pad_reg))
        else $error("digest shown before length was padded");
`endif

endmodule
`default_nettype wire

>>> hdl/shamh_round.sv
// one sha-256 compression round, reused for every round of a block
`timescale 1ns / 1ps
`default_nettype none
module shamh_round (
    input  wire shamh_pkg::work_t  work_in,
    input  wire logic [31:0]       round_key,
    input  wire logic [31:0]       sched_word,
    output shamh_pkg::work_t       work_out
);

    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        ch  = (work_in.e & work_in.f) ^ (~work_in.e & work_in.g);
        maj = (work_in.a & work_in.b) ^ (work_in.a & work_in.c) ^ (work_in.b & work_in.c);
        t1  = work_in.h + shamh_pkg::big_sigma1(work_in.e) + ch + round_key + sched_word;
        t2  = shamh_pkg::big_sigma0(work_in.a) + maj;

        work_out.h = work_in.g;
        work_out.g = work_in.f;
        work_out.f = work_in.e;
        work_out.e = work_in.d + t1;
        work_out.d = work_in.c;
        work_out.c = work_in.b;
        work_out.b = work_in.a;
        work_out.a = t1 + t2;
    end

endmodule
`default_nettype wire

>>> tb/sha256_message_hasher_tb.sv
// self-checking testbench for the streaming sha-256 message hasher
`timescale 1ns / 1ps

module sha256_message_hasher_tb;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // lengths around the padding and block boundaries
    localparam int BOUNDARY_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [31:0] m_tdata;
    wire logic [2:0]  m_tuser;
    wire logic        m_tlast;

    sha256_message_hasher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predicted hash state
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    logic [60:0] msg_bytes;

    digest_word_t digest_q [$];
    int err_count = 0;

    // sender and receiver pacing
    int  burst_left  = 0;
    int  tx_max_gap  = 12;
    bit  rx_free_run = 1'b0;
    bit  rx_busy     = 1'b0;
    int  rx_hold     = 0;
    int  msg_items   = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_restart();
        for (int i = 0; i < 8; i++) begin
            hash_state[i] = SHA_IV[i];
        end
        msg_bytes = '0;
    endtask

    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25))
                   + ((e & f) ^ (~e & g)) + SHA_K[t] + w[t];
            t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22))
                   + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    // absorb one accepted request; an end request pads and queues the digest
    task automatic sha_absorb(input logic [7:0] data, input logic present, input logic ends);
        int pos;
        logic [63:0] bit_len;
        digest_word_t dw;
        if (present) begin
            block_bytes[msg_bytes[5:0]] = data;
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[5:0] == 6'd0) begin
                sha_compress();
            end
        end
        if (ends) begin
            pos = msg_bytes[5:0];
            block_bytes[pos] = 8'h80;
            pos++;
            // no room for the length field, spill into an extra block
            if (pos > 56) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                sha_compress();
                pos = 0;
            end
            while (pos < 56) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            bit_len = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++) begin
                block_bytes[56+i] = bit_len[63-8*i -: 8];
            end
            sha_compress();
            for (int i = 0; i < 8; i++) begin
                dw.word  = hash_state[i];
                dw.index = 3'(i);
                dw.last  = (i == 7);
                digest_q = {digest_q, dw};
            end
            sha_restart();
        end
    endtask

    task automatic send_item(input logic [7:0] data, input logic present, input logic ends);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            if (tx_max_gap != 0) begin
                gap = $urandom_range(tx_max_gap, 1);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= ends;
        do @(posedge aclk); while (!s_tready);
        sha_absorb(data, present, ends);
    endtask

    task automatic wait_digests();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (digest_q.size() != 0) @(posedge aclk);
    endtask

    // random bytes, optional ignored requests, end on the last byte or on its own
    task automatic send_message(input int len);
        logic end_on_byte;
        end_on_byte = (len != 0) && ($urandom_range(1, 0) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9, 0) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
        msg_items += len + (end_on_byte ? 0 : 1);
    endtask

    task automatic test_empty_message();
        send_item(8'hff, 1'b0, 1'b1);
        wait_digests();
    endtask

    task automatic test_byte_with_end();
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        wait_digests();
    endtask

    task automatic test_end_after_bytes();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_digests();
    endtask

    task automatic test_ignored_items();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'hc3, 1'b0, 1'b0);
        send_item(8'h3c, 1'b1, 1'b1);
        // a second empty message right after checks that the state came back
        send_item(8'h81, 1'b0, 1'b1);
        wait_digests();
    endtask

    task automatic test_random_messages();
        int kind;
        int len;
        int msgs;
        msgs = 0;
        msg_items = 0;
        while (msg_items < 230 || msgs < 4) begin
            kind = $urandom_range(9, 0);
            if (kind < 4) begin
                len = $urandom_range(20, 0);
            end else if (kind < 8) begin
                len = BOUNDARY_LEN[$urandom_range(9, 0)];
            end else begin
                len = $urandom_range(140, 0);
            end
            tx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 12;
            send_message(len);
            msgs++;
            if ($urandom_range(2, 0) == 0) begin
                wait_digests();
            end
        end
        wait_digests();
    endtask

    task automatic test_streaming_no_gaps();
        tx_max_gap  = 0;
        rx_free_run = 1'b1;
        send_message(64);
        send_message($urandom_range(60, 1));
        send_message(0);
        send_message(56);
        wait_digests();
    endtask

    // receiver: alternating ready and stall stretches of random length
    always @(posedge aclk) begin
        if (rx_free_run) begin
            m_tready <= 1'b1;
        end else if (rx_hold == 0) begin
            rx_busy = ~rx_busy;
            rx_hold = rx_busy ? $urandom_range(12, 1) : $urandom_range(6, 1);
            m_tready <= ~rx_busy;
        end else begin
            rx_hold--;
        end
    end

    always @(posedge aclk) begin : check_digest
        digest_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest request, got word %h index %0d last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = digest_q.pop_front();
                if (m_tdata !== want.word) begin
                    $display("%0t: digest word mismatch, expected %h, got %h",
                             $time, want.word, m_tdata);
                    err_count++;
                end
                if (m_tuser !== want.index) begin
                    $display("%0t: word index mismatch, expected %0d, got %0d",
                             $time, want.index, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last word mismatch, expected %b, got %b",
                             $time, want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 64; i++) begin
            block_bytes[i] = 8'h00;
        end
        sha_restart();
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_byte_with_end();
        test_end_after_bytes();
        test_ignored_items();
        test_random_messages();
        test_streaming_no_gaps();

        repeat (100) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
